@@ design/multi_osc_wavetable_dds_macros.svh @@
// Assertion helpers for the oscillator bank checkers.
// Every assertion is clocked on the rising edge and disabled while reset is low.
`ifndef MULTI_OSC_WAVETABLE_DDS_MACROS_SVH
`define MULTI_OSC_WAVETABLE_DDS_MACROS_SVH

`define MOWDDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define MOWDDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `MOWDDS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define MOWDDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  `MOWDDS_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ design/mowdds_pkg.sv @@
// ----------------------------------------------------------------------------
// mowdds_pkg
// Types, constants and helpers shared by the wavetable oscillator bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mowdds_pkg;

  localparam int NUM_OSC_DEFAULT   = 6;
  localparam int NUM_WAVES_DEFAULT = 4;
  localparam int WAVE_LENGTH       = 256;
  localparam int WAVE_IDX_W        = 8;
  localparam int NUM_LFSRS         = 3;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOAD
  } state_e;

  // Galois step: lsb tested before the shift.
  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    logic [15:0] sh;
    sh = s >> 1;
    return s[0] ? (sh ^ LFSR_TAPS) : sh;
  endfunction

endpackage

`default_nettype wire

@@ design/mowdds_if.sv @@
// ----------------------------------------------------------------------------
// mowdds_in_if / mowdds_out_if
// Valid/ready channels for command words in and sample words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mowdds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  osc_select;
  logic [31:0] tuning_word;
  logic [1:0]  wave_select;
  logic        noise_enable;
  logic [7:0]  phase_offset;
  logic [9:0]  table_address;
  logic [7:0]  table_data;

  modport source (
    output valid, op, osc_select, tuning_word, wave_select, noise_enable,
           phase_offset, table_address, table_data,
    input  ready
  );
  modport sink (
    input  valid, op, osc_select, tuning_word, wave_select, noise_enable,
           phase_offset, table_address, table_data,
    output ready
  );
endinterface

interface mowdds_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] osc_number;
  logic [7:0] sample;
  logic       last;

  modport source (output valid, osc_number, sample, last, input ready);
  modport sink   (input  valid, osc_number, sample, last, output ready);
endinterface

`default_nettype wire

@@ design/multi_osc_wavetable_dds.sv @@
// Op 1 and op 2 words complete in the cycle they are accepted.
// A tick word sweeps the oscillators in turn: ST_CALC adds through the one shared phase
// adder and reads the single-port wave RAM, ST_LOAD takes the registered read data (or the
// noise byte) into the output register, waiting while the sink stalls; no command word is
// taken until it ends. Reset clears phases and oscillator settings and seeds the LFSRs;
// the wave RAM is not cleared, so the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// multi_osc_wavetable_dds
// Bank of 32-bit phase accumulator oscillators served in turn through one
// adder and one wavetable RAM, with three Galois LFSR noise sources.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_osc_wavetable_dds
  import mowdds_pkg::*;
#(
  parameter int NUM_OSCILLATORS = NUM_OSC_DEFAULT,
  parameter int NUM_WAVES       = NUM_WAVES_DEFAULT
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  mowdds_in_if.sink          in_i,
  mowdds_out_if.source       out_o
);

  localparam int OscW     = (NUM_OSCILLATORS > 1) ? $clog2(NUM_OSCILLATORS) : 1;
  localparam int MemDepth = NUM_WAVES * WAVE_LENGTH;
  localparam int MemAw    = $clog2(MemDepth);

  // Wave choice wraps on the segment count; applied once, when the setting is written.
  function automatic logic [1:0] wave_wrap(input logic [1:0] w_in);
    logic [1:0] w;
    w = w_in;
    for (int i = 0; i < 4; i++) begin
      if (32'(w) >= NUM_WAVES) begin
        w = w - 2'(NUM_WAVES);
      end
    end
    return w;
  endfunction

  logic [31:0] phase_q [NUM_OSCILLATORS];
  logic [31:0] incr_q  [NUM_OSCILLATORS];
  logic [1:0]  wave_q  [NUM_OSCILLATORS];
  logic        noise_q [NUM_OSCILLATORS];
  logic [7:0]  shift_q [NUM_OSCILLATORS];
  logic [15:0] lfsr_q  [NUM_LFSRS];

  state_e          state_q, state_d;
  logic [OscW-1:0] osc_q, osc_d;
  logic            load_out;

  logic             accept, tick_acc, set_acc, wr_acc;
  logic [31:0]      phase_sum;
  logic [7:0]       tbl_idx;
  logic [MemAw-1:0] rd_addr, raddr_q, ram_addr;
  logic             ram_we;
  logic [7:0]       ram_rdata;

  logic [3:0] osc_ext;
  logic [2:0] pair;
  logic [1:0] lfsr_sel;
  logic [7:0] noise_byte, sample_d;
  logic       osc_last, slot_free;

  logic       out_valid_q;
  logic [2:0] out_num_q;
  logic [7:0] out_sample_q;
  logic       out_last_q;

  // --------------------------------------------------------------------------
  // Command decode
  // --------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign tick_acc   = accept && (in_i.op == OP_TICK);
  assign set_acc    = accept && (in_i.op == OP_SET) &&
                      (32'(in_i.osc_select) < NUM_OSCILLATORS);
  assign wr_acc     = accept && (in_i.op == OP_WRITE) &&
                      (32'(in_i.table_address) < MemDepth);

  // --------------------------------------------------------------------------
  // Shared phase adder and table address
  // --------------------------------------------------------------------------
  assign phase_sum = phase_q[osc_q] + incr_q[osc_q];
  assign tbl_idx   = phase_sum[31:24] + shift_q[osc_q];
  assign rd_addr   = (MemAw'(wave_q[osc_q]) << WAVE_IDX_W) | MemAw'(tbl_idx);

  always_comb begin
    unique case (state_q)
      ST_IDLE: ram_addr = MemAw'(in_i.table_address);
      ST_CALC: ram_addr = rd_addr;
      ST_LOAD: ram_addr = raddr_q;   // held so stalled read data stays put
      default: ram_addr = raddr_q;
    endcase
  end

  assign ram_we = wr_acc;

  mowdds_ram #(
    .WIDTH (8),
    .DEPTH (MemDepth)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_i.table_data),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Noise byte: LFSR (k/2) mod 3, high byte for odd k
  // --------------------------------------------------------------------------
  assign osc_ext = 4'(osc_q);
  assign pair    = osc_ext[3:1];

  always_comb begin
    if (pair >= 3'd6) begin
      lfsr_sel = 2'(pair - 3'd6);
    end else if (pair >= 3'd3) begin
      lfsr_sel = 2'(pair - 3'd3);
    end else begin
      lfsr_sel = 2'(pair);
    end
  end

  assign noise_byte = osc_ext[0] ? lfsr_q[lfsr_sel][15:8] : lfsr_q[lfsr_sel][7:0];
  assign sample_d   = noise_q[osc_q] ? noise_byte : ram_rdata;
  assign osc_last   = (osc_q == OscW'(NUM_OSCILLATORS - 1));
  assign slot_free  = !out_valid_q || out_o.ready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      osc_q   <= '0;
    end else begin
      state_q <= state_d;
      osc_q   <= osc_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    osc_d    = osc_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (tick_acc) begin
          state_d = ST_CALC;
          osc_d   = '0;
        end
      end
      ST_CALC: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (osc_last) begin
            state_d = ST_IDLE;
          end else begin
            osc_d   = osc_q + 1'b1;
            state_d = ST_CALC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Oscillator state and LFSRs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_OSCILLATORS; i++) begin
        phase_q[i] <= '0;
        incr_q[i]  <= '0;
        wave_q[i]  <= '0;
        noise_q[i] <= 1'b0;
        shift_q[i] <= '0;
      end
      for (int j = 0; j < NUM_LFSRS; j++) begin
        lfsr_q[j] <= LFSR_SEED;
      end
    end else begin
      if (set_acc) begin
        incr_q[OscW'(in_i.osc_select)]  <= in_i.tuning_word;
        wave_q[OscW'(in_i.osc_select)]  <= wave_wrap(in_i.wave_select);
        noise_q[OscW'(in_i.osc_select)] <= in_i.noise_enable;
        shift_q[OscW'(in_i.osc_select)] <= in_i.phase_offset;
      end
      if (state_q == ST_CALC) begin
        phase_q[osc_q] <= phase_sum;
      end
      if (tick_acc) begin
        for (int j = 0; j < NUM_LFSRS; j++) begin
          lfsr_q[j] <= lfsr_next(lfsr_q[j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      raddr_q <= rd_addr;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_num_q    <= 3'(osc_q);
      out_sample_q <= sample_d;
      out_last_q   <= osc_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.osc_number = out_num_q;
  assign out_o.sample     = out_sample_q;
  assign out_o.last       = out_last_q;

endmodule

`default_nettype wire

@@ design/mowdds_ram.sv @@
// ----------------------------------------------------------------------------
// mowdds_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mowdds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/mowdds_checker.sv @@
// ----------------------------------------------------------------------------
// mowdds_checker
// Port-level checks on the oscillator bank, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_osc_wavetable_dds_macros.svh"

module mowdds_checker
  import mowdds_pkg::*;
#(
  parameter int NUM_OSCILLATORS = NUM_OSC_DEFAULT
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic [1:0] in_op_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] out_osc_number_i,
  input wire logic [7:0] out_sample_i,
  input wire logic       out_last_i
);

  // A stalled sample word holds.
  `MOWDDS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_osc_number_i) && $stable(out_sample_i) && $stable(out_last_i), "sample word changed while stalled")

  // Last flag only on the final oscillator's word.
  `MOWDDS_ASSERT_IMP(a_last_num, clk_i, rst_ni, out_valid_i && out_last_i, out_osc_number_i == 3'(NUM_OSCILLATORS - 1), "last set on wrong oscillator")

  // Mid-tick: no new command word is taken.
  `MOWDDS_ASSERT_IMP(a_busy_mid, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i, "ready while a tick is unfinished")

  // A tick starts the sweep.
  `MOWDDS_ASSERT_NXT(a_tick_busy, clk_i, rst_ni, in_valid_i && in_ready_i && (in_op_i == OP_TICK), !in_ready_i, "ready right after a tick")

endmodule

bind multi_osc_wavetable_dds mowdds_checker #(
  .NUM_OSCILLATORS (NUM_OSCILLATORS)
) u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_op_i          (in_i.op),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_osc_number_i (out_o.osc_number),
  .out_sample_i     (out_o.sample),
  .out_last_i       (out_o.last)
);

`default_nettype wire
